// File: design/pqm_pkg.sv
// Shared types, opcodes and constants for the PQ bus power mismatch block.
// No dependencies; imported by the top level and pqm_cordic.
`timescale 1ns / 1ps
`default_nettype none

package pqm_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_LINE     = 2'd1,
        OP_LINE_FIN = 2'd2,
        OP_FINISH   = 2'd3
    } opcode_t;

    localparam int CORDIC_STEPS = 30;
    localparam int IN_DATA_W    = 192;
    localparam int OUT_DATA_W   = 104;

    typedef enum logic [4:0] {
        S_IDLE,
        S_VV,
        S_VVC,
        S_CWAIT,
        S_GC,
        S_BS,
        S_GS,
        S_BC,
        S_TQ,
        S_ABS,
        S_PLO,
        S_PHI,
        S_QLO,
        S_QHI,
        S_QFIN,
        S_QACC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_status_t;

    // atan(2^-i) scaled so that a quarter turn is 2^30
    function automatic logic signed [32:0] atan_lut(input logic [4:0] idx);
        logic signed [32:0] r;
        unique case (idx)
            5'd0:  r = 33'sh020000000;
            5'd1:  r = 33'sh012E4051E;
            5'd2:  r = 33'sh009FB385B;
            5'd3:  r = 33'sh0051111D4;
            5'd4:  r = 33'sh0028B0D43;
            5'd5:  r = 33'sh00145D7E1;
            5'd6:  r = 33'sh000A2F61E;
            5'd7:  r = 33'sh000517C55;
            5'd8:  r = 33'sh00028BE53;
            5'd9:  r = 33'sh000145F2F;
            5'd10: r = 33'sh0000A2F98;
            5'd11: r = 33'sh0000517CC;
            5'd12: r = 33'sh000028BE6;
            5'd13: r = 33'sh0000145F3;
            5'd14: r = 33'sh00000A2FA;
            5'd15: r = 33'sh00000517D;
            5'd16: r = 33'sh0000028BE;
            5'd17: r = 33'sh00000145F;
            5'd18: r = 33'sh000000A30;
            5'd19: r = 33'sh000000518;
            5'd20: r = 33'sh00000028C;
            5'd21: r = 33'sh000000146;
            5'd22: r = 33'sh0000000A3;
            5'd23: r = 33'sh000000051;
            5'd24: r = 33'sh000000029;
            5'd25: r = 33'sh000000014;
            5'd26: r = 33'sh00000000A;
            5'd27: r = 33'sh000000005;
            5'd28: r = 33'sh000000003;
            5'd29: r = 33'sh000000001;
            default: r = 33'sh000000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/pq_bus_power_mismatch_top.sv
// Top level of the PQ bus power mismatch block: stream ports, sequencer, accumulators.
// Depends on pqm_pkg, pqm_mul and pqm_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Computes the P and Q mismatch of one PQ bus from a stream of requests. A begin
// request (tuser 0) loads the bus voltage, angle, shunt G/B and the P/Q set values;
// line requests (tuser 1, or 2 to also finish) add one line's flow; a finish
// request (tuser 3) emits the saturated Q24.24 residuals and the saturation flag.
// The block takes one request at a time and drops s_tready while it works. A line
// request runs a 30-step CORDIC for sin/cos of the angle difference and nine
// products on the single shared 33x33 multiplier, each product registered before
// use. A result waits in the output register until taken; the next request is held
// off only if a new result would overwrite one still waiting.
module pq_bus_power_mismatch_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] voltage, [63:32] angle, [95:64] conductance, [127:96] susceptance,
    // [159:128] p_set, [191:160] q_set
    input  wire logic [191:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [47:0] p_mismatch, [95:48] q_mismatch, [96] saturated, [103:97] zero
    output logic [103:0]      m_tdata
);
    import pqm_pkg::*;

    state_t              state_reg, state_next;
    opcode_t             op_reg;
    logic [31:0]         bus_v_reg, bus_ang_reg, v_reg, vv_reg, lo_reg;
    logic signed [31:0]  g_reg, b_reg;
    logic signed [63:0]  tp_reg, tq_reg;
    logic [62:0]         mp_reg, mq_reg;
    logic                np_reg, nq_reg;
    logic [49:0]         mag_reg;
    logic signed [47:0]  p_acc_reg, q_acc_reg;
    logic                sat_reg;
    logic                out_valid_reg;
    logic [96:0]         out_data_reg;

    logic                in_fire, cordic_start, emit_ok;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;
    logic signed [31:0]  cos_v, sin_v;
    cordic_status_t      cst;
    logic [63:0]         mag_sum;
    logic [48:0]         p_add, q_add;

    opcode_t             s_op;
    logic [31:0]         s_volt, s_ang;
    logic signed [31:0]  s_g, s_b, s_pset, s_qset;

    assign s_op   = opcode_t'(s_tuser);
    assign s_volt = s_tdata[31:0];
    assign s_ang  = s_tdata[63:32];
    assign s_g    = s_tdata[95:64];
    assign s_b    = s_tdata[127:96];
    assign s_pset = s_tdata[159:128];
    assign s_qset = s_tdata[191:160];

    // acc + or - mag, saturated to 48 bits; top bit is the clamp flag
    function automatic logic [48:0] sat_add(input logic signed [47:0] acc,
                                            input logic [49:0] mag, input logic neg);
        logic signed [51:0] s;
        logic [48:0]        r;
        if (neg)
            s = {{4{acc[47]}}, acc} - {2'b00, mag};
        else
            s = {{4{acc[47]}}, acc} + {2'b00, mag};
        if (s[51:47] == 5'b00000 || s[51:47] == 5'b11111)
            r = {1'b0, s[47:0]};
        else if (s[51])
            r = {1'b1, 1'b1, 47'd0};
        else
            r = {1'b1, 1'b0, {47{1'b1}}};
        return r;
    endfunction

    pqm_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pqm_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (bus_ang_reg - s_ang),
        .cos_out (cos_v),
        .sin_out (sin_v),
        .status  (cst)
    );

    assign in_fire = s_tvalid && s_tready;
    assign emit_ok = !out_valid_reg || m_tready;

    // floor((hi*2^32 + lo) / 2^46) from the two partial products
    assign mag_sum = prod[63:0] + {32'd0, lo_reg};
    assign p_add   = sat_add(p_acc_reg, mag_reg, np_reg);
    assign q_add   = sat_add(q_acc_reg, mag_reg, nq_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_op == OP_FINISH)
                        state_next = S_EMIT;
                    else
                        state_next = S_VV;
                end
            end
            S_VV:    state_next = S_VVC;
            S_VVC:   state_next = (op_reg == OP_BEGIN) ? S_ABS : S_CWAIT;
            S_CWAIT: state_next = cst.done ? S_GC : S_CWAIT;
            S_GC:    state_next = S_BS;
            S_BS:    state_next = S_GS;
            S_GS:    state_next = S_BC;
            S_BC:    state_next = S_TQ;
            S_TQ:    state_next = S_ABS;
            S_ABS:   state_next = S_PLO;
            S_PLO:   state_next = S_PHI;
            S_PHI:   state_next = S_QLO;
            S_QLO:   state_next = S_QHI;
            S_QHI:   state_next = S_QFIN;
            S_QFIN:  state_next = S_QACC;
            S_QACC:  state_next = (op_reg == OP_LINE_FIN) ? S_EMIT : S_IDLE;
            S_EMIT:  state_next = emit_ok ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        s_tready     = (state_reg == S_IDLE);
        cordic_start = in_fire && (s_op == OP_LINE || s_op == OP_LINE_FIN);
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            S_VV: begin
                mul_a = {1'b0, bus_v_reg};
                mul_b = {1'b0, v_reg};
            end
            S_GC: begin mul_a = 33'(g_reg); mul_b = 33'(cos_v); end
            S_BS: begin mul_a = 33'(b_reg); mul_b = 33'(sin_v); end
            S_GS: begin mul_a = 33'(g_reg); mul_b = 33'(sin_v); end
            S_BC: begin mul_a = 33'(b_reg); mul_b = 33'(cos_v); end
            S_PLO: begin
                mul_a = {1'b0, mp_reg[31:0]};
                mul_b = {1'b0, vv_reg};
            end
            S_PHI: begin
                mul_a = {2'b00, mp_reg[62:32]};
                mul_b = {1'b0, vv_reg};
            end
            S_QLO: begin
                mul_a = {1'b0, mq_reg[31:0]};
                mul_b = {1'b0, vv_reg};
            end
            S_QHI: begin
                mul_a = {2'b00, mq_reg[62:32]};
                mul_b = {1'b0, vv_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bus_v_reg     <= '0;
            bus_ang_reg   <= '0;
            p_acc_reg     <= '0;
            q_acc_reg     <= '0;
            sat_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && emit_ok)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (in_fire && s_op == OP_BEGIN) begin
                bus_v_reg   <= s_volt;
                bus_ang_reg <= s_ang;
                sat_reg     <= 1'b0;
                p_acc_reg   <= 48'sd0 - {{8{s_pset[31]}}, s_pset, 8'd0};
                q_acc_reg   <= 48'sd0 - {{8{s_qset[31]}}, s_qset, 8'd0};
            end
            if (state_reg == S_QHI) begin
                p_acc_reg <= p_add[47:0];
                if (p_add[48])
                    sat_reg <= 1'b1;
            end
            if (state_reg == S_QACC) begin
                q_acc_reg <= q_add[47:0];
                if (q_add[48])
                    sat_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg <= s_op;
            v_reg  <= s_volt;
            g_reg  <= s_g;
            b_reg  <= s_b;
        end
        unique case (state_reg)
            S_VVC: begin
                vv_reg <= prod[63:32];
                // shunt terms: G*2^30 and -B*2^30
                tp_reg <= {{2{g_reg[31]}}, g_reg, 30'd0};
                tq_reg <= 64'sd0 - {{2{b_reg[31]}}, b_reg, 30'd0};
            end
            S_BS: tp_reg <= prod[63:0];
            S_GS: tp_reg <= tp_reg + prod[63:0];
            S_BC: tq_reg <= prod[63:0];
            S_TQ: tq_reg <= tq_reg - prod[63:0];
            S_ABS: begin
                np_reg <= tp_reg[63];
                nq_reg <= tq_reg[63];
                mp_reg <= tp_reg[63] ? 63'(64'sd0 - tp_reg) : tp_reg[62:0];
                mq_reg <= tq_reg[63] ? 63'(64'sd0 - tq_reg) : tq_reg[62:0];
            end
            S_PHI:  lo_reg  <= prod[63:32];
            S_QLO:  mag_reg <= mag_sum[63:14];
            S_QHI:  lo_reg  <= prod[63:32];
            S_QFIN: mag_reg <= mag_sum[63:14];
            default: begin
            end
        endcase
        if (state_reg == S_EMIT && emit_ok)
            out_data_reg <= {sat_reg, q_acc_reg, p_acc_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    // sin/cos must be ready before the first product that uses them
    a_cordic_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GC) |-> cst.done)
        else $error("products started before CORDIC finished");

    // a begin request clears the saturation flag
    a_begin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_BEGIN) |=> !sat_reg)
        else $error("saturation flag not cleared on begin");

    // a finish request goes straight to the emit step
    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_FINISH) |=> (state_reg == S_EMIT))
        else $error("finish request did not reach emit");

    // no CORDIC run while the sequencer is in the emit step
    a_cordic_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !cst.busy)
        else $error("CORDIC busy during emit");

endmodule

`default_nettype wire

// File: design/pqm_mul.sv
// Shared 33x33 signed multiplier with registered product.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
`default_nettype none

module pqm_mul (
    input  wire logic               aclk,
    input  wire logic signed [32:0] op_a,
    input  wire logic signed [32:0] op_b,
    output logic signed [65:0]      prod
);
    logic signed [65:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: design/pqm_cordic.sv
// Iterative CORDIC, one rotation per cycle, then quadrant fold and clamp.
// Depends on pqm_pkg (atan table, status struct).
`timescale 1ns / 1ps
`default_nettype none

module pqm_cordic (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [31:0]           angle,
    output logic signed [31:0]         cos_out,
    output logic signed [31:0]         sin_out,
    output pqm_pkg::cordic_status_t    status
);
    import pqm_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic                busy_reg, fin_reg, done_reg;
    logic [4:0]          cnt_reg;
    logic [1:0]          quad_reg;
    logic signed [33:0]  x_reg, y_reg;
    logic signed [32:0]  z_reg;
    logic signed [31:0]  cos_reg, sin_reg;

    logic signed [33:0]  xs, ys, c_raw, s_raw;
    logic signed [32:0]  at;

    function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh040000000)
            r = 32'sh40000000;
        else if (v < -34'sh040000000)
            r = -32'sh40000000;
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = atan_lut(cnt_reg);
        unique case (quad_reg)
            2'd0: begin c_raw = x_reg;  s_raw = y_reg;  end
            2'd1: begin c_raw = -y_reg; s_raw = x_reg;  end
            2'd2: begin c_raw = -x_reg; s_raw = -y_reg; end
            default: begin c_raw = y_reg; s_raw = -x_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= 34'sd652032874;
            y_reg    <= '0;
            z_reg    <= {3'b000, angle[29:0]};
            quad_reg <= angle[31:30];
        end else if (busy_reg) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (fin_reg) begin
            cos_reg <= clamp30(c_raw);
            sin_reg <= clamp30(s_raw);
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
    assign status  = {busy_reg | fin_reg, done_reg};

endmodule

`default_nettype wire
